@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/zcbf_pkg.sv @@
// Package with types and constants of the burst-fire heater controller.
`timescale 1ns / 1ps
package zcbf_pkg;

  localparam int unsigned TEMP_W   = 10;
  localparam int unsigned DIFF_W   = TEMP_W + 1;
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned ON_W     = 3;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [TIMER_W-1:0] FIRE_DELAY_RESET = 16'd2128;

  // Error thresholds of the control update.
  localparam logic signed [DIFF_W-1:0] DIFF_HIGH = 11'sd20;
  localparam logic signed [DIFF_W-1:0] DIFF_MID  = 11'sd10;
  localparam logic signed [DIFF_W-1:0] DIFF_LOW  = 11'sd5;
  localparam logic signed [DIFF_W-1:0] DIFF_ZERO = 11'sd0;

  // Burst patterns picked by the control update.
  localparam logic [COUNT_W-1:0] PERIOD_FAST = 5'd5;
  localparam logic [COUNT_W-1:0] PERIOD_SLOW = 5'd20;
  localparam logic [COUNT_W-1:0] PERIOD_IDLE = 5'd2;
  localparam logic [ON_W-1:0]    ON_FULL     = 3'd5;
  localparam logic [ON_W-1:0]    ON_HALF     = 3'd2;
  localparam logic [ON_W-1:0]    ON_LOW      = 3'd1;
  localparam logic [ON_W-1:0]    ON_TRIM     = 3'd3;
  localparam logic [ON_W-1:0]    ON_NONE     = 3'd0;

  // Register index of the fire delay on the configuration port.
  localparam logic REG_FIRE_DELAY = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_RISE   = 2'd1,
    OP_FALL   = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef struct packed {
    logic [COUNT_W-1:0] period;
    logic [ON_W-1:0]    on_count;
    logic               heating;
  } burst_t;

  typedef struct packed {
    logic indicator;
    logic gate;
  } result_t;

endpackage

@@ hdl/zcbf_burst.sv @@
// Burst pattern selection from the temperature error.
`timescale 1ns / 1ps
module zcbf_burst (
  input  logic [zcbf_pkg::TEMP_W-1:0] setpoint,
  input  logic [zcbf_pkg::TEMP_W-1:0] measured,
  output zcbf_pkg::burst_t            burst
);

  logic signed [zcbf_pkg::DIFF_W-1:0] diff;

  assign diff = $signed({1'b0, setpoint}) - $signed({1'b0, measured});

  always_comb begin
    burst.heating = 1'b1;
    if (diff > zcbf_pkg::DIFF_HIGH) begin
      burst.period   = zcbf_pkg::PERIOD_FAST;
      burst.on_count = zcbf_pkg::ON_FULL;
    end else if (diff > zcbf_pkg::DIFF_MID) begin
      burst.period   = zcbf_pkg::PERIOD_FAST;
      burst.on_count = zcbf_pkg::ON_HALF;
    end else if (diff > zcbf_pkg::DIFF_LOW) begin
      burst.period   = zcbf_pkg::PERIOD_FAST;
      burst.on_count = zcbf_pkg::ON_LOW;
    end else if (diff > zcbf_pkg::DIFF_ZERO) begin
      burst.period   = zcbf_pkg::PERIOD_SLOW;
      burst.on_count = zcbf_pkg::ON_TRIM;
    end else begin
      burst.period   = zcbf_pkg::PERIOD_IDLE;
      burst.on_count = zcbf_pkg::ON_NONE;
      burst.heating  = 1'b0;
    end
  end

endmodule

@@ hdl/zcbf_core.sv @@
// Event processing: cycle counter, fire delay timer and gate state.
`timescale 1ns / 1ps
module zcbf_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  zcbf_pkg::op_t                op,
  input  logic                         enable,
  input  logic [zcbf_pkg::TEMP_W-1:0]  setpoint,
  input  logic [zcbf_pkg::TEMP_W-1:0]  measured,
  input  logic [zcbf_pkg::TIMER_W-1:0] fire_delay,
  output zcbf_pkg::result_t            result_nxt
);

  logic [zcbf_pkg::COUNT_W-1:0] cycle_count_r, cycle_count_nxt;
  logic [zcbf_pkg::COUNT_W-1:0] period_r, period_nxt;
  logic [zcbf_pkg::ON_W-1:0]    on_count_r, on_count_nxt;
  logic                         gate_r, gate_nxt;
  logic                         running_r, running_nxt;
  logic [zcbf_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic                         indicator_r, indicator_nxt;

  logic [zcbf_pkg::TIMER_W-1:0] timer_inc;
  logic [zcbf_pkg::COUNT_W-1:0] count_inc;
  logic [zcbf_pkg::COUNT_W-1:0] count_wrap;
  logic [zcbf_pkg::COUNT_W-1:0] on_wide;
  zcbf_pkg::burst_t             burst;

  zcbf_burst u_burst (
    .setpoint (setpoint),
    .measured (measured),
    .burst    (burst)
  );

  assign timer_inc  = timer_r + zcbf_pkg::TIMER_W'(1);
  assign count_inc  = cycle_count_r + zcbf_pkg::COUNT_W'(1);
  assign count_wrap = (count_inc > period_r) ? '0 : count_inc;
  assign on_wide    = {{(zcbf_pkg::COUNT_W - zcbf_pkg::ON_W){1'b0}}, on_count_r};

  always_comb begin
    cycle_count_nxt = cycle_count_r;
    period_nxt      = period_r;
    on_count_nxt    = on_count_r;
    gate_nxt        = gate_r;
    running_nxt     = running_r;
    timer_nxt       = timer_r;
    indicator_nxt   = indicator_r;
    if (accept) begin
      case (op)
        zcbf_pkg::OP_TICK: begin
          if (running_r) begin
            timer_nxt = timer_inc;
            if (timer_inc == fire_delay) begin
              running_nxt = 1'b0;
              timer_nxt   = '0;
              if (cycle_count_r < on_wide) begin
                gate_nxt = 1'b1;
              end
            end
          end
        end
        zcbf_pkg::OP_RISE: begin
          if (!enable) begin
            gate_nxt = 1'b0;
          end else begin
            cycle_count_nxt = count_wrap;
            if (count_wrap >= on_wide) begin
              gate_nxt = 1'b0;
            end
          end
        end
        zcbf_pkg::OP_FALL: begin
          if (!enable) begin
            gate_nxt = 1'b0;
          end else begin
            running_nxt = 1'b1;
          end
        end
        zcbf_pkg::OP_UPDATE: begin
          period_nxt    = burst.period;
          on_count_nxt  = burst.on_count;
          indicator_nxt = burst.heating;
          if (burst.heating) begin
            cycle_count_nxt = '0;
          end
        end
        default: begin
          gate_nxt = gate_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_count_r <= '0;
      period_r      <= '0;
      on_count_r    <= '0;
      gate_r        <= 1'b0;
      running_r     <= 1'b0;
      timer_r       <= '0;
      indicator_r   <= 1'b0;
    end else begin
      cycle_count_r <= cycle_count_nxt;
      period_r      <= period_nxt;
      on_count_r    <= on_count_nxt;
      gate_r        <= gate_nxt;
      running_r     <= running_nxt;
      timer_r       <= timer_nxt;
      indicator_r   <= indicator_nxt;
    end
  end

  assign result_nxt.gate      = gate_nxt;
  assign result_nxt.indicator = indicator_nxt;

endmodule

@@ hdl/zero_cross_burst_fire_heater.sv @@
// Top level of the zero-cross burst-fire triac heater controller.
`timescale 1ns / 1ps
//
//  Channel   Direction  Contents
//  in_*      slave      one event request: operation in tuser, enable and temperatures
//  out_*     master     one result request per event: triac gate and heating indicator
//  cfg_*     APB slave  fire delay register at byte address 0
//
// For every event, the state registers in the core update at the edge that accepts the
// request, and the result register holds the state after it.
// A new request is accepted in every cycle while the result register is empty or
// being drained, so a stalled result side holds back only the input side.
// Reset is synchronous and active low; it returns all state to zero, the fire delay
// to 2128 ticks and empties the result register.
module zero_cross_burst_fire_heater (
  input  logic        clk,
  input  logic        rst_n,
  // Input events.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [0] enable, [10:1] setpoint, [20:11] measured
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] triac_on, [1] heating_indicator
  // Configuration.
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [zcbf_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [zcbf_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [zcbf_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic                         in_accept;
  logic                         cfg_write;
  logic [zcbf_pkg::TIMER_W-1:0] fire_delay_r;
  logic                         out_valid_r, out_valid_nxt;
  zcbf_pkg::result_t            out_result_r;
  zcbf_pkg::result_t            result_nxt;

  // The result register frees up in the same cycle it is drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  zcbf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .op         (zcbf_pkg::op_t'(in_tuser)),
    .enable     (in_tdata[0]),
    .setpoint   (in_tdata[10:1]),
    .measured   (in_tdata[20:11]),
    .fire_delay (fire_delay_r),
    .result_nxt (result_nxt)
  );

  // Configuration port: the single register is decoded from the word index bit.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_delay_r <= zcbf_pkg::FIRE_DELAY_RESET;
    end else if (cfg_write && (cfg_paddr[2] == zcbf_pkg::REG_FIRE_DELAY)) begin
      fire_delay_r <= cfg_pwdata[zcbf_pkg::TIMER_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == zcbf_pkg::REG_FIRE_DELAY) begin
      cfg_prdata = {{(zcbf_pkg::DATA_W - zcbf_pkg::TIMER_W){1'b0}}, fire_delay_r};
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_result_r.indicator, out_result_r.gate};

endmodule

@@ hdl/zcbf_checker.sv @@
// Port-level checker for the heater controller and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module zcbf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  logic in_acc;
  logic edge_off;
  logic update_acc;

  assign in_acc     = in_tvalid && in_tready;
  assign edge_off   = in_acc && !in_tdata[0] &&
                      ((in_tuser == zcbf_pkg::OP_RISE) || (in_tuser == zcbf_pkg::OP_FALL));
  assign update_acc = in_acc && (in_tuser == zcbf_pkg::OP_UPDATE);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_NEXT(a_result_follows, clk, rst_n, in_acc, out_tvalid)
  `ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)
  `ASSERT_NEXT(a_disabled_edge_off, clk, rst_n, edge_off, !out_tdata[0])
  `ASSERT_NEXT(a_indicator, clk, rst_n, update_acc, out_tdata[1] == ($past(in_tdata[10:1]) > $past(in_tdata[20:11])))

endmodule

bind zero_cross_burst_fire_heater zcbf_checker u_zcbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
